// ----- sv/ntsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ntsp_pkg: shared types and constants for the nearest target selector
// Holds the configuration register map, the configuration bundle and the
// per-item control flags passed between the distance and tracking stages.
// ----------------------------------------------------------------------------
package ntsp_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_REF_X            = 3'd0,
    CFG_REF_Y            = 3'd1,
    CFG_DIST_LIMIT_SQ    = 3'd2,
    CFG_MAX_CANDIDATES   = 3'd3,
    CFG_SATURATION_COUNT = 3'd4,
    CFG_HITS_NEEDED      = 3'd5,
    CFG_MISSES_TO_CLEAR  = 3'd6,
    CFG_MISSES_TO_REPORT = 3'd7
  } cfg_index_t;

  // Register file contents
  typedef struct packed {
    logic [14:0] ref_x;
    logic [14:0] ref_y;
    logic [31:0] dist_limit_sq;
    logic [3:0]  max_candidates;
    logic [3:0]  saturation_count;
    logic [7:0]  hits_needed;
    logic [7:0]  misses_to_clear;
    logic [7:0]  misses_to_report;
  } cfg_t;

  // Reset values of the register file
  localparam logic [14:0] REF_X_RESET            = 15'd4160;
  localparam logic [14:0] REF_Y_RESET            = 15'd5344;
  localparam logic [31:0] DIST_LIMIT_SQ_RESET    = 32'd256000;
  localparam logic [3:0]  MAX_CANDIDATES_RESET   = 4'd6;
  localparam logic [3:0]  SATURATION_COUNT_RESET = 4'd6;
  localparam logic [7:0]  HITS_NEEDED_RESET      = 8'd3;
  localparam logic [7:0]  MISSES_TO_CLEAR_RESET  = 8'd2;
  localparam logic [7:0]  MISSES_TO_REPORT_RESET = 8'd5;

  // Centre x marking a rejected circle (minus one pixel in Q11.4)
  localparam int REJECT_X = -16;

  // Saturation value of the hit and miss counters
  localparam logic [7:0] CNT_MAX = 8'hFF;

  // Per-item flags from the distance stage to the tracking stage
  typedef struct packed {
    logic present;
    logic last;
    logic rejected;
  } item_ctl_t;

endpackage

// ----- sv/ntsp_dist.sv -----
// ----------------------------------------------------------------------------
// ntsp_dist: input register and squared distance stage
// Registers each incoming item, computes its exact squared distance to the
// reference point and flags rejected circles, then hands the result on.
// ----------------------------------------------------------------------------
module ntsp_dist #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // incoming items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_present,
  input  logic                                in_last,
  input  logic signed [COORD_WIDTH-1:0]       in_cx,
  input  logic signed [COORD_WIDTH-1:0]       in_cy,
  // reference point
  input  logic [14:0]                         ref_x,
  input  logic [14:0]                         ref_y,
  // items with distance
  output logic                                out_valid,
  input  logic                                out_ready,
  output ntsp_pkg::item_ctl_t                 out_ctl,
  output logic signed [COORD_WIDTH-1:0]       out_cx,
  output logic signed [COORD_WIDTH-1:0]       out_cy,
  output logic [2*(((COORD_WIDTH > 16) ? COORD_WIDTH : 16)):0] out_dist
);
  import ntsp_pkg::*;

  // signed difference width, magnitude width, squared sum width
  localparam int EW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
  localparam int AW = EW - 1;
  localparam int DW = 2 * AW + 1;
  localparam logic signed [COORD_WIDTH-1:0] RejX = COORD_WIDTH'(REJECT_X);

  // input register
  logic                          v1;
  logic                          p1;
  logic                          l1;
  logic signed [COORD_WIDTH-1:0] cx1;
  logic signed [COORD_WIDTH-1:0] cy1;
  logic                          adv1;

  logic signed [EW-1:0]          dx;
  logic signed [EW-1:0]          dy;
  logic [AW-1:0]                 ax;
  logic [AW-1:0]                 ay;
  logic [2*AW-1:0]               sqx;
  logic [2*AW-1:0]               sqy;
  logic [DW-1:0]                 sq_dist;

  assign adv1     = v1 && (!out_valid || out_ready);
  assign in_ready = !v1 || adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_valid && in_ready) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p1  <= in_present;
      l1  <= in_last;
      cx1 <= in_cx;
      cy1 <= in_cy;
    end
  end

  // exact squared distance, magnitudes first to keep the multipliers unsigned
  always_comb begin
    dx      = $signed(EW'(ref_x)) - EW'(cx1);
    dy      = $signed(EW'(ref_y)) - EW'(cy1);
    ax      = dx[EW-1] ? AW'(-dx) : AW'(dx);
    ay      = dy[EW-1] ? AW'(-dy) : AW'(dy);
    sqx     = (2*AW)'(ax) * (2*AW)'(ax);
    sqy     = (2*AW)'(ay) * (2*AW)'(ay);
    sq_dist = DW'(sqx) + DW'(sqy);
  end

  // distance register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv1) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      out_ctl.present  <= p1;
      out_ctl.last     <= l1;
      out_ctl.rejected <= (cx1 == RejX);
      out_cx           <= cx1;
      out_cy           <= cy1;
      out_dist         <= sq_dist;
    end
  end

endmodule

// ----- sv/ntsp_track.sv -----
// ----------------------------------------------------------------------------
// ntsp_track: candidate selection, persistence filter and result register
// Keeps the running best candidate of the frame, runs the hit and miss
// counters at the end of each frame and holds the report for the output.
// ----------------------------------------------------------------------------
module ntsp_track #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ntsp_pkg::cfg_t                      cfg,
  // items with distance
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ntsp_pkg::item_ctl_t                 in_ctl,
  input  logic signed [COORD_WIDTH-1:0]       in_cx,
  input  logic signed [COORD_WIDTH-1:0]       in_cy,
  input  logic [2*(((COORD_WIDTH > 16) ? COORD_WIDTH : 16)):0] in_dist,
  // reports
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH:0]         out_dir_x,
  output logic signed [COORD_WIDTH:0]         out_dir_y,
  output logic [3:0]                          out_count,
  output logic                                out_found
);
  import ntsp_pkg::*;

  localparam int EW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
  localparam int DW = 2 * (EW - 1) + 1;

  // frame and filter state
  logic [3:0]                    frame_count;
  logic signed [COORD_WIDTH-1:0] best_x;
  logic signed [COORD_WIDTH-1:0] best_y;
  logic [DW-1:0]                 best_dist;
  logic [7:0]                    hit_count;
  logic [7:0]                    miss_count;

  logic [3:0]                    frame_count_next;
  logic signed [COORD_WIDTH-1:0] best_x_next;
  logic signed [COORD_WIDTH-1:0] best_y_next;
  logic [DW-1:0]                 best_dist_next;
  logic [7:0]                    hit_count_next;
  logic [7:0]                    miss_count_next;

  logic                          consider;
  logic                          first;
  logic                          better;
  logic [DW-1:0]                 cur_dist;
  logic [3:0]                    n;
  logic [7:0]                    hit_inc;
  logic [7:0]                    miss_inc;
  logic                          produce;
  logic                          found;
  logic signed [EW-1:0]          ox;
  logic signed [EW-1:0]          oy;
  logic                          fire;

  // a result-producing item waits only while the report register is stuck
  assign in_ready = !in_valid || !produce || !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // candidate update and end-of-frame decision
  always_comb begin
    consider = in_ctl.present && (frame_count < cfg.max_candidates);
    first    = (frame_count == 4'd0);
    cur_dist = first ? DW'(cfg.dist_limit_sq) : best_dist;
    better   = !in_ctl.rejected && (in_dist < cur_dist);

    best_x_next      = best_x;
    best_y_next      = best_y;
    best_dist_next   = best_dist;
    frame_count_next = frame_count;
    if (consider) begin
      if (better || first) begin
        best_x_next = in_cx;
        best_y_next = in_cy;
      end
      best_dist_next   = better ? in_dist : cur_dist;
      frame_count_next = frame_count + 4'd1;
    end

    n        = frame_count_next;
    hit_inc  = (hit_count == CNT_MAX) ? hit_count : hit_count + 8'd1;
    miss_inc = (miss_count == CNT_MAX) ? miss_count : miss_count + 8'd1;

    hit_count_next  = hit_count;
    miss_count_next = miss_count;
    produce         = 1'b0;
    found           = 1'b0;
    if (in_ctl.last) begin
      frame_count_next = 4'd0;
      if (n != 4'd0 && n < cfg.saturation_count) begin
        // hit frame
        hit_count_next = hit_inc;
        if (hit_inc >= cfg.hits_needed) begin
          produce         = 1'b1;
          found           = 1'b1;
          miss_count_next = 8'd0;
        end
      end else begin
        // miss frame
        miss_count_next = miss_inc;
        if (miss_inc >= cfg.misses_to_clear) begin
          hit_count_next = 8'd0;
        end
        if (miss_inc >= cfg.misses_to_report) begin
          miss_count_next = 8'd0;
          produce         = 1'b1;
        end
      end
    end

    ox = $signed(EW'(best_x_next)) - $signed(EW'(cfg.ref_x));
    oy = $signed(EW'(cfg.ref_y)) - $signed(EW'(best_y_next));
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 4'd0;
      best_x      <= '0;
      best_y      <= '0;
      best_dist   <= '0;
      hit_count   <= 8'd0;
      miss_count  <= 8'd0;
    end else if (fire) begin
      frame_count <= frame_count_next;
      best_x      <= best_x_next;
      best_y      <= best_y_next;
      best_dist   <= best_dist_next;
      hit_count   <= hit_count_next;
      miss_count  <= miss_count_next;
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_found <= found;
      out_dir_x <= found ? ox[COORD_WIDTH:0] : '0;
      out_dir_y <= found ? oy[COORD_WIDTH:0] : '0;
      out_count <= found ? n : 4'd0;
    end
  end

endmodule

// ----- sv/nearest_target_select_with_persistence_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_target_select_with_persistence_unit: nearest circle tracker
// Picks the circle of each frame nearest to a reference point and filters
// the frame outcomes through hit and miss counters before reporting.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             contents
//  s_*       in   s_tvalid / s_tready   one circle or empty-frame marker
//  m_*       out  m_tvalid / m_tready   direction or no-ball report
//  cfg_*     in   cfg_valid / cfg_ready register write, always ready
//
// One item is taken every cycle unless the input is stalled. An item passes
// an input register, the squared distance register and the selection logic;
// a frame's report enters the output register as its last item is selected.
// Only an item that yields a report can stall, and only while the previous
// report is still waiting; the input then backs up behind it.
// Reset is synchronous; it clears all counters, the running best and the
// register file to its defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_target_select_with_persistence_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // input stream
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // tdata fields from bit 0: cand_x, cand_y, zero pad
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]            s_tdata,
  // tuser fields from bit 0: present
  input  logic                                          s_tuser,
  input  logic                                          s_tlast,
  // output stream
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // tdata fields from bit 0: dir_x, dir_y, ball_count, zero pad
  output logic [((2*(COORD_WIDTH+1)+4+7)/8)*8-1:0]      m_tdata,
  // tuser fields from bit 0: found
  output logic                                          m_tuser,
  // configuration writes
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [2:0]                                    cfg_index,
  input  logic [31:0]                                   cfg_data
);
  import ntsp_pkg::*;

  localparam int EW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
  localparam int DW = 2 * (EW - 1) + 1;
  localparam int OW = ((2*(COORD_WIDTH+1)+4+7)/8)*8;

  cfg_t                          cfg;

  logic                          d_valid;
  logic                          d_ready;
  item_ctl_t                     d_ctl;
  logic signed [COORD_WIDTH-1:0] d_cx;
  logic signed [COORD_WIDTH-1:0] d_cy;
  logic [DW-1:0]                 d_dist;

  logic signed [COORD_WIDTH:0]   dir_x;
  logic signed [COORD_WIDTH:0]   dir_y;
  logic [3:0]                    ball_count;

  // register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_x            <= REF_X_RESET;
      cfg.ref_y            <= REF_Y_RESET;
      cfg.dist_limit_sq    <= DIST_LIMIT_SQ_RESET;
      cfg.max_candidates   <= MAX_CANDIDATES_RESET;
      cfg.saturation_count <= SATURATION_COUNT_RESET;
      cfg.hits_needed      <= HITS_NEEDED_RESET;
      cfg.misses_to_clear  <= MISSES_TO_CLEAR_RESET;
      cfg.misses_to_report <= MISSES_TO_REPORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_REF_X:            cfg.ref_x            <= cfg_data[14:0];
        CFG_REF_Y:            cfg.ref_y            <= cfg_data[14:0];
        CFG_DIST_LIMIT_SQ:    cfg.dist_limit_sq    <= cfg_data;
        CFG_MAX_CANDIDATES:   cfg.max_candidates   <= cfg_data[3:0];
        CFG_SATURATION_COUNT: cfg.saturation_count <= cfg_data[3:0];
        CFG_HITS_NEEDED:      cfg.hits_needed      <= cfg_data[7:0];
        CFG_MISSES_TO_CLEAR:  cfg.misses_to_clear  <= cfg_data[7:0];
        CFG_MISSES_TO_REPORT: cfg.misses_to_report <= cfg_data[7:0];
        default:              cfg.ref_x            <= cfg.ref_x;
      endcase
    end
  end

  // distance stage
  ntsp_dist #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk                   (clk),
    .rst                   (rst),
    .in_valid              (s_tvalid),
    .in_ready              (s_tready),
    .in_present            (s_tuser),
    .in_last               (s_tlast),
    .in_cx                 (s_tdata[COORD_WIDTH-1:0]),
    .in_cy                 (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .ref_x                 (cfg.ref_x),
    .ref_y                 (cfg.ref_y),
    .out_valid             (d_valid),
    .out_ready             (d_ready),
    .out_ctl               (d_ctl),
    .out_cx                (d_cx),
    .out_cy                (d_cy),
    .out_dist              (d_dist)
  );

  // selection and persistence stage
  ntsp_track #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_ctl    (d_ctl),
    .in_cx     (d_cx),
    .in_cy     (d_cy),
    .in_dist   (d_dist),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_dir_x (dir_x),
    .out_dir_y (dir_y),
    .out_count (ball_count),
    .out_found (m_tuser)
  );

  assign m_tdata = OW'({ball_count, dir_y, dir_x});

  // checks
  a_found_has_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> ball_count != 4'd0)
    else $error("direction report with zero count");

  a_noball_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("no-ball report carries data");

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a blocked report");

endmodule

// ----- tb/tb_nearest_target_select_with_persistence_unit.sv -----
// ----------------------------------------------------------------------------
// tb_nearest_target_select_with_persistence_unit: self-checking bench
// Streams frames of circle centres into the tracker and checks every report
// against a cycle-free tracker written here. A short directed set covers
// the corner cases, then random register settings and random frames run
// with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_nearest_target_select_with_persistence_unit;
  import ntsp_pkg::*;

  localparam int CW           = 16;
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 8;     // settling time after the last report
  localparam int LONG_HOLD    = 300;
  localparam int ITEM_TARGET  = 1100;

  // One circle or frame marker waiting to be sent
  typedef struct {
    logic        present;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    int          gap;
  } circle_t;

  // One expected report
  typedef struct packed {
    logic [16:0] dir_x;
    logic [16:0] dir_y;
    logic [3:0]  ball_count;
    logic        found;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // cand_x, cand_y
  logic        s_tuser = 1'b0; // present
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // dir_x, dir_y, ball_count, zero pad
  logic        m_tuser;        // found
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_REF_X;
  logic [31:0] cfg_data = '0;

  nearest_target_select_with_persistence_unit #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Register copy, updated when a write transaction completes
  cfg_t regs = '{ref_x: REF_X_RESET, ref_y: REF_Y_RESET,
                 dist_limit_sq: DIST_LIMIT_SQ_RESET,
                 max_candidates: MAX_CANDIDATES_RESET,
                 saturation_count: SATURATION_COUNT_RESET,
                 hits_needed: HITS_NEEDED_RESET,
                 misses_to_clear: MISSES_TO_CLEAR_RESET,
                 misses_to_report: MISSES_TO_REPORT_RESET};

  // Tracker state
  int          frame_n = 0;
  logic [15:0] best_x = '0;
  logic [15:0] best_y = '0;
  longint      best_d = 0;
  int          hit_n = 0;
  int          miss_n = 0;

  circle_t circle_q[$];
  report_t reports_due[$];
  int      items_queued = 0;
  int      errors = 0;

  bit in_took = 0;
  bit out_took = 0;
  bit tx_burst = 0;
  bit rx_burst = 0;
  int hold_req = 0;

  task automatic flag_error(string what, logic [31:0] got, logic [31:0] want);
    // keep the log readable if the block is badly broken
    if (errors < 100)
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  // Frame tracker: nearest circle selection and hit/miss persistence
  task automatic track_item(logic present, logic [15:0] cx, logic [15:0] cy,
                            logic last);
    longint  dx, dy, d, ox, oy;
    int      n;
    report_t r;
    if (present && frame_n < int'(regs.max_candidates)) begin
      if (frame_n == 0) begin
        best_x = cx;
        best_y = cy;
        best_d = longint'(regs.dist_limit_sq);
      end
      if (int'($signed(cx)) != REJECT_X) begin
        dx = longint'(regs.ref_x) - longint'($signed(cx));
        dy = longint'(regs.ref_y) - longint'($signed(cy));
        d = dx * dx + dy * dy;
        if (d < best_d) begin
          best_d = d;
          best_x = cx;
          best_y = cy;
        end
      end
      frame_n++;
    end
    if (last) begin
      n = frame_n;
      frame_n = 0;
      if (n > 0 && n < int'(regs.saturation_count)) begin
        if (hit_n < int'(CNT_MAX)) hit_n++;
        if (hit_n >= int'(regs.hits_needed)) begin
          ox = longint'($signed(best_x)) - longint'(regs.ref_x);
          oy = longint'(regs.ref_y) - longint'($signed(best_y));
          r.dir_x = ox[16:0];
          r.dir_y = oy[16:0];
          r.ball_count = 4'(n);
          r.found = 1'b1;
          reports_due.push_back(r);
          miss_n = 0;
        end
      end else begin
        if (miss_n < int'(CNT_MAX)) miss_n++;
        if (miss_n >= int'(regs.misses_to_clear)) hit_n = 0;
        if (miss_n >= int'(regs.misses_to_report)) begin
          miss_n = 0;
          reports_due.push_back('0);
        end
      end
    end
  endtask

  // Monitor: check reports, feed accepted items to the tracker
  always @(posedge clk) begin : monitor
    report_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_took = 1;
        if (reports_due.size() == 0) begin
          flag_error("unexpected report, tdata", m_tdata[31:0], '0);
        end else begin
          want = reports_due.pop_front();
          if (m_tdata[16:0] !== want.dir_x)
            flag_error("dir_x", 32'(m_tdata[16:0]), 32'(want.dir_x));
          if (m_tdata[33:17] !== want.dir_y)
            flag_error("dir_y", 32'(m_tdata[33:17]), 32'(want.dir_y));
          if (m_tdata[37:34] !== want.ball_count)
            flag_error("ball_count", 32'(m_tdata[37:34]), 32'(want.ball_count));
          if (m_tuser !== want.found)
            flag_error("found", 32'(m_tuser), 32'(want.found));
        end
      end
      if (s_tvalid && s_tready) begin
        in_took = 1;
        track_item(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tlast);
      end
    end
  end

  // Input driver: offers queued items after their drawn gap
  always @(negedge clk) begin : driver
    logic    nv;
    circle_t c;
    nv = s_tvalid;
    if (!rst) begin
      if (in_took) begin
        in_took = 0;
        nv = 1'b0;
      end
      if (!nv && circle_q.size() > 0) begin
        if (circle_q[0].gap > 0) begin
          circle_q[0].gap = circle_q[0].gap - 1;
        end else begin
          c = circle_q.pop_front();
          nv = 1'b1;
          s_tdata <= {c.y, c.x};
          s_tuser <= c.present;
          s_tlast <= c.last;
        end
      end
    end
    s_tvalid <= nv;
  end

  // Output receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin : receiver
    int hold_left;
    int rdy_wait;
    int hold_seen;
    if (!rst) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (out_took) begin
        out_took = 0;
        if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
        rdy_wait = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rdy_wait > 0) begin
        rdy_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic push_item(logic present, logic [15:0] x, logic [15:0] y,
                           logic last);
    circle_t c;
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
    c.present = present;
    c.x = x;
    c.y = y;
    c.last = last;
    c.gap = tx_burst ? 0 : $urandom_range(0, 16);
    circle_q.push_back(c);
    if (present || last) items_queued++;
  endtask

  task automatic cfg_write(cfg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REF_X:            regs.ref_x = val[14:0];
      CFG_REF_Y:            regs.ref_y = val[14:0];
      CFG_DIST_LIMIT_SQ:    regs.dist_limit_sq = val;
      CFG_MAX_CANDIDATES:   regs.max_candidates = val[3:0];
      CFG_SATURATION_COUNT: regs.saturation_count = val[3:0];
      CFG_HITS_NEEDED:      regs.hits_needed = val[7:0];
      CFG_MISSES_TO_CLEAR:  regs.misses_to_clear = val[7:0];
      CFG_MISSES_TO_REPORT: regs.misses_to_report = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(cfg_t c);
    cfg_write(CFG_REF_X, 32'(c.ref_x));
    cfg_write(CFG_REF_Y, 32'(c.ref_y));
    cfg_write(CFG_DIST_LIMIT_SQ, c.dist_limit_sq);
    cfg_write(CFG_MAX_CANDIDATES, 32'(c.max_candidates));
    cfg_write(CFG_SATURATION_COUNT, 32'(c.saturation_count));
    cfg_write(CFG_HITS_NEEDED, 32'(c.hits_needed));
    cfg_write(CFG_MISSES_TO_CLEAR, 32'(c.misses_to_clear));
    cfg_write(CFG_MISSES_TO_REPORT, 32'(c.misses_to_report));
  endtask

  // Sender pauses until every report is in and the pipeline has drained
  task automatic wait_idle();
    while (circle_q.size() != 0 || s_tvalid || reports_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Coordinate near a centre, anywhere, or at an extreme
  function automatic logic [15:0] pick_coord(logic [14:0] centre);
    int off;
    int k;
    k = $urandom_range(0, 9);
    off = $urandom_range(0, 2000);
    if (k < 5) return 16'(int'(centre) + off - 1000);
    if (k < 8) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // One random frame: mostly hit-sized, some empty, some crowded
  task automatic queue_frame(bit single);
    int          n;
    int          hit_max;
    int          r;
    bit          marker_end;
    logic [15:0] x;
    hit_max = int'(regs.max_candidates);
    if (int'(regs.saturation_count) - 1 < hit_max)
      hit_max = int'(regs.saturation_count) - 1;
    if (hit_max < 1) hit_max = 1;
    r = $urandom_range(0, 99);
    if (single) n = (r < 5) ? 0 : 1;
    else if (r < 12) n = 0;
    else if (r < 25) n = $urandom_range(int'(regs.saturation_count), 17);
    else n = $urandom_range(1, hit_max);
    if (n == 0) begin
      push_item(1'b0, 16'($urandom), 16'($urandom), 1'b1);
    end else begin
      marker_end = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
        // ignored filler inside a frame
        if ($urandom_range(0, 9) == 0)
          push_item(1'b0, 16'($urandom), 16'($urandom), 1'b0);
        x = ($urandom_range(0, 7) == 0) ? 16'(REJECT_X) : pick_coord(regs.ref_x);
        push_item(1'b1, x, pick_coord(regs.ref_y), (i == n - 1) && !marker_end);
      end
      if (marker_end) push_item(1'b0, 16'($urandom), 16'($urandom), 1'b1);
    end
  endtask

  task automatic run_phase(int n_items, bit single);
    int start;
    start = items_queued;
    while (items_queued - start < n_items) queue_frame(single);
    wait_idle();
  endtask

  initial begin : stimulus
    cfg_t        c;
    logic [15:0] rx, ry;
    int          phases;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset settings
    rx = 16'(regs.ref_x);
    ry = 16'(regs.ref_y);
    push_item(1'b0, 16'h0000, 16'h0000, 1'b1);            // empty frame
    push_item(1'b1, rx + 16'd10, ry - 16'd20, 1'b1);       // one close circle
    // rejected first circle that nothing beats
    push_item(1'b1, 16'(REJECT_X), 16'd100, 1'b0);
    push_item(1'b1, 16'h7FFF, 16'h8000, 1'b1);
    // nearest wins, with an ignored marker inside; third hit reports
    push_item(1'b1, 16'h8000, 16'h7FFF, 1'b0);
    push_item(1'b1, rx + 16'd5, ry + 16'd5, 1'b0);
    push_item(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    push_item(1'b1, rx - 16'd3, ry + 16'd1, 1'b1);
    // crowded frame: extra circles past the candidate limit
    for (int i = 0; i < 7; i++)
      push_item(1'b1, rx + 16'(i), ry - 16'(i), i == 6);
    push_item(1'b0, 16'h0000, 16'h0000, 1'b1);            // second miss clears
    wait_idle();

    // Directed, upper extremes
    c.ref_x = 15'h7FFF; c.ref_y = 15'h0000; c.dist_limit_sq = 32'hFFFF_FFFF;
    c.max_candidates = 4'd15; c.saturation_count = 4'd15;
    c.hits_needed = 8'd1; c.misses_to_clear = 8'd1; c.misses_to_report = 8'd1;
    set_regs(c);
    push_item(1'b1, 16'h7FFF, 16'h0000, 1'b1);
    push_item(1'b1, 16'h8000, 16'h7FFF, 1'b1);
    wait_idle();

    // Directed, zero settings: no candidate counts, thresholds always met
    c.ref_x = 15'h0000; c.ref_y = 15'h7FFF; c.dist_limit_sq = 32'h0;
    c.max_candidates = 4'd0; c.saturation_count = 4'd0;
    c.hits_needed = 8'd0; c.misses_to_clear = 8'd0; c.misses_to_report = 8'd0;
    set_regs(c);
    push_item(1'b0, 16'h0000, 16'h0000, 1'b1);
    push_item(1'b1, 16'h0000, 16'h7FFF, 1'b1);
    wait_idle();

    // Every frame reports; receiver holds off so the block backs up
    c.ref_x = 15'($urandom); c.ref_y = 15'($urandom);
    c.dist_limit_sq = $urandom_range(0, 1 << 26);
    c.max_candidates = 4'd15; c.saturation_count = 4'd15;
    c.hits_needed = 8'd1; c.misses_to_clear = 8'd1; c.misses_to_report = 8'd1;
    set_regs(c);
    hold_req++;
    run_phase(100, 1'b0);

    // Counter saturation: long run of single-circle hit frames
    c.hits_needed = 8'd255; c.misses_to_clear = 8'd255; c.misses_to_report = 8'd255;
    set_regs(c);
    run_phase(270, 1'b1);

    // Random settings, random frames
    phases = 0;
    while (items_queued < ITEM_TARGET && phases < 60) begin
      c.ref_x = 15'($urandom);
      c.ref_y = 15'($urandom);
      case ($urandom_range(0, 4))
        0: c.dist_limit_sq = $urandom;
        1: c.dist_limit_sq = DIST_LIMIT_SQ_RESET;
        2: c.dist_limit_sq = $urandom_range(0, 1 << 20);
        3: c.dist_limit_sq = $urandom_range(0, 1 << 26);
        default: c.dist_limit_sq = 32'hFFFF_FFFF;
      endcase
      c.max_candidates = 4'($urandom_range(1, 15));
      c.saturation_count = 4'($urandom_range(1, 15));
      c.hits_needed = 8'($urandom_range(1, 4));
      c.misses_to_clear = 8'($urandom_range(1, 6));
      c.misses_to_report = 8'($urandom_range(1, 6));
      set_regs(c);
      run_phase($urandom_range(60, 120), 1'b0);
      phases++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
